[design/wlns_pkg.sv]
package wlns_pkg;

  // sizes
  localparam int MAX_ORDER = 32;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ORD_W     = $clog2(MAX_ORDER + 1);
  localparam int SAMP_W    = 24;
  localparam int COEF_W    = 18;
  localparam int ST_W      = 32;
  localparam int ACC_W     = 47;
  localparam int MB_W      = COEF_W + 1;
  localparam int PROD_W    = ACC_W + MB_W;
  localparam int RND_W     = PROD_W - 17;
  localparam int RND23_W   = PROD_W - 23;
  localparam int SUM_W     = 50;

  // accumulator limits and saturation bounds
  localparam logic signed [SUM_W-1:0] SAMP_LIM  = SUM_W'(64'sd1 <<< 40);
  localparam logic signed [SUM_W-1:0] SCALE_LIM = SUM_W'(64'sd1 <<< 45);
  localparam logic signed [SUM_W-1:0] S32_MAX   = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] S32_MIN   = SUM_W'(-64'sd2147483648);
  localparam logic signed [ACC_W-1:0] SCALE_ONE = ACC_W'(64'sd1 <<< 30);
  localparam logic signed [ST_W-1:0]  UNIT_SCALE = ST_W'(64'sd1 <<< 23);

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_COEF   = 2'd1,
    FUNC_APPLY  = 2'd2,
    FUNC_RESET  = 2'd3
  } func_t;

  // datapath micro operations: multiply, then write back
  typedef enum logic [3:0] {
    OP_AP1, OP_AP2, OP_AP3,
    OP_LA1, OP_LA2,
    OP_LN1, OP_LN2,
    OP_SB,
    OP_PA1, OP_PA2,
    OP_SC
  } op_t;

  typedef struct packed {
    logic             load_sample;
    logic             load_apply;
    logic             write_coef;
    logic             clear_state;
    logic             mul_en;
    logic             wb_en;
    op_t              op;
    logic             scale_mode;
    logic [IDX_W-1:0] idx;
    logic             div_start;
    logic             pred_init;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic             div_done;
  } sts_t;

  // shift right by 17 rounding half up
  function automatic logic signed [RND_W-1:0] rnd17(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = (p + (PROD_W'(1) << 16)) >>> 17;
    return s[RND_W-1:0];
  endfunction

  // shift right by 23 rounding half up
  function automatic logic signed [RND23_W-1:0] rnd23(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = (p + (PROD_W'(1) << 22)) >>> 23;
    return s[RND23_W-1:0];
  endfunction

  function automatic logic signed [ST_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > S32_MAX) c = S32_MAX;
    else if (v < S32_MIN) c = S32_MIN;
    else c = v;
    return c[ST_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [SUM_W-1:0] v,
                                                        input logic scale_mode);
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] c;
    lim = scale_mode ? SCALE_LIM : SAMP_LIM;
    if (v > lim) c = lim;
    else if (v < -lim) c = -lim;
    else c = v;
    return c[ACC_W-1:0];
  endfunction

endpackage

[design/wlns_div.sv]
module wlns_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [wlns_pkg::ACC_W-1:0] divisor,
  output logic                              done,
  output logic signed [wlns_pkg::ST_W-1:0]  quotient
);
  import wlns_pkg::*;

  localparam int QUO_W = 54;
  localparam int D_W   = ACC_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ACC_W-1:0]        rem_r, rem_nxt;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  logic [D_W-1:0]          d_r, d_nxt;
  logic                    neg_r, neg_nxt;
  logic [ACC_W-1:0]        rem_sh;
  logic [ACC_W-1:0]        abs_div;

  assign abs_div = divisor[ACC_W-1] ? ACC_W'(-divisor) : ACC_W'(divisor);
  // numerator is a single one at its top bit
  assign rem_sh  = {rem_r[ACC_W-2:0], cnt_r == '0};

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = '0;
      d_nxt    = abs_div[D_W-1:0];
      neg_nxt  = divisor[ACC_W-1];
    end else if (busy_r) begin
      if (rem_sh >= ACC_W'(d_r)) begin
        rem_nxt = rem_sh - ACC_W'(d_r);
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  // sign and saturate to 32 bits; a zero divisor gives all ones and so the top value
  always_comb begin
    if (neg_r) begin
      if (quo_r >= (QUO_W'(1) << 31)) quotient = {1'b1, {(ST_W-1){1'b0}}};
      else quotient = ST_W'(-quo_r[ST_W-1:0]);
    end else begin
      if (quo_r > QUO_W'(32'h7fffffff)) quotient = {1'b0, {(ST_W-1){1'b1}}};
      else quotient = quo_r[ST_W-1:0];
    end
  end

  assign done = done_r;

endmodule

[design/wlns_dp.sv]
module wlns_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wlns_pkg::cmd_t                     cmd,
  output wlns_pkg::sts_t                     sts,
  input  logic signed [wlns_pkg::SAMP_W-1:0] in_sample,
  input  logic [wlns_pkg::IDX_W-1:0]         in_coef_index,
  input  logic signed [wlns_pkg::COEF_W-1:0] in_coef_value,
  input  logic signed [wlns_pkg::COEF_W-1:0] in_new_lambda,
  input  logic [wlns_pkg::ORD_W-1:0]         in_new_order,
  output logic signed [wlns_pkg::SAMP_W-1:0] out_shaping_term
);
  import wlns_pkg::*;

  logic signed [ST_W-1:0]   state_r   [MAX_ORDER];
  logic signed [COEF_W-1:0] active_r  [MAX_ORDER];
  logic signed [COEF_W-1:0] pending_r [MAX_ORDER];
  logic signed [COEF_W-1:0] lam_r;
  logic [ORD_W-1:0]         order_r;
  logic [ORD_W-1:0]         old_order_r;
  logic signed [ST_W-1:0]   scale_r;
  logic signed [ST_W-1:0]   term_r;
  logic signed [ACC_W-1:0]  a_r, b_r, nua_r, nub_r;
  logic signed [ST_W-1:0]   t_r, t2_r;
  logic signed [RND_W-1:0]  ak_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [SAMP_W-1:0] out_r;

  logic signed [ACC_W-1:0]  mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_ab;
  logic signed [ST_W-1:0]   nua_sat;
  logic signed [2*ST_W-1:0] prod_sc;
  logic signed [ST_W-1:0]   st_cur;
  logic signed [COEF_W-1:0] k_cur;
  logic signed [RND_W-1:0]  r;
  logic signed [SUM_W-1:0]  y;
  logic signed [ST_W:0]     out_sum;
  logic signed [ST_W:0]     out_shr;
  logic signed [ST_W-1:0]   div_q;
  logic                     div_done;
  logic [ORD_W-1:0]         ord_clip;

  assign st_cur  = state_r[cmd.idx];
  assign k_cur   = active_r[cmd.idx];
  assign r       = rnd17(p_r);
  assign nua_sat = sat32(SUM_W'(nua_r));
  assign y       = SUM_W'(in_sample) * SUM_W'(8) - SUM_W'(term_r);
  assign ord_clip = (in_new_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : in_new_order;

  // operand selection for the shared multiplier
  always_comb begin
    unique case (cmd.op)
      OP_AP1, OP_PA1: begin mul_a = ACC_W'(st_cur); mul_b = MB_W'(lam_r);   end
      OP_AP2, OP_PA2: begin mul_a = ACC_W'(t_r);    mul_b = MB_W'(lam_r);   end
      OP_AP3:         begin mul_a = ACC_W'(t2_r);   mul_b = MB_W'(lam_r);   end
      OP_LA1:         begin mul_a = a_r;            mul_b = MB_W'(k_cur);   end
      OP_LA2:         begin mul_a = b_r;            mul_b = MB_W'(k_cur);   end
      OP_LN1:         begin mul_a = nua_r;          mul_b = MB_W'(k_cur);   end
      OP_LN2:         begin mul_a = nub_r;          mul_b = MB_W'(k_cur);   end
      OP_SB:          begin mul_a = b_r;            mul_b = -MB_W'(lam_r);  end
      default:        begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  assign prod_ab = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_sc = (2*ST_W)'(nua_sat) * (2*ST_W)'(scale_r);

  // output rounding to q3.20
  assign out_sum = (ST_W+1)'(term_r) + (ST_W+1)'(4);
  assign out_shr = out_sum >>> 3;

  wlns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (a_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        state_r[i]   <= '0;
        active_r[i]  <= '0;
        pending_r[i] <= '0;
      end
      lam_r       <= '0;
      order_r     <= '0;
      old_order_r <= '0;
      scale_r     <= UNIT_SCALE;
      term_r      <= '0;
    end else begin
      if (cmd.write_coef) pending_r[in_coef_index] <= in_coef_value;
      if (cmd.load_apply) begin
        lam_r       <= in_new_lambda;
        old_order_r <= order_r;
        order_r     <= ord_clip;
      end
      if (cmd.clear_state) begin
        for (int i = 0; i < MAX_ORDER; i++) state_r[i] <= '0;
        term_r <= '0;
      end
      if (cmd.pred_init) scale_r <= div_q;
      if (cmd.wb_en) begin
        unique case (cmd.op)
          OP_AP2: state_r[cmd.idx] <= t_r;
          OP_SB: begin
            active_r[cmd.idx] <= pending_r[cmd.idx];
            if (ORD_W'(cmd.idx) >= old_order_r) state_r[cmd.idx] <= '0;
          end
          OP_SC: term_r <= sat32(SUM_W'(rnd23(p_r)));
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.mul_en) p_r <= (cmd.op == OP_SC) ? PROD_W'(prod_sc) : prod_ab;
    if (cmd.load_sample) begin
      a_r   <= y[ACC_W-1:0];
      b_r   <= y[ACC_W-1:0];
      nua_r <= '0;
      nub_r <= '0;
    end else if (cmd.load_apply) begin
      a_r <= SCALE_ONE;
      b_r <= SCALE_ONE;
    end else if (cmd.pred_init) begin
      nua_r <= '0;
      nub_r <= '0;
    end else if (cmd.wb_en) begin
      unique case (cmd.op)
        // first all-pass of the sample pass reads b, not nub
        OP_AP1: t_r <= sat32(SUM_W'(b_r) + SUM_W'(r));
        OP_PA1: t_r <= sat32(SUM_W'(nub_r) + SUM_W'(r));
        OP_AP2: begin
          b_r  <= clamp_acc(SUM_W'(st_cur) - SUM_W'(r), cmd.scale_mode);
          t2_r <= sat32(SUM_W'(nub_r) + SUM_W'(r));
        end
        OP_AP3: nub_r <= clamp_acc(SUM_W'(t_r) - SUM_W'(r), cmd.scale_mode);
        OP_LA1, OP_LN1: ak_r <= r;
        OP_LA2: begin
          a_r <= clamp_acc(SUM_W'(a_r) - SUM_W'(r), cmd.scale_mode);
          b_r <= clamp_acc(SUM_W'(b_r) - SUM_W'(ak_r), cmd.scale_mode);
        end
        OP_LN2: begin
          nua_r <= clamp_acc(SUM_W'(nua_r) - SUM_W'(r), cmd.scale_mode);
          nub_r <= clamp_acc(SUM_W'(nub_r) - SUM_W'(ak_r), cmd.scale_mode);
        end
        OP_SB:  b_r <= clamp_acc(SUM_W'(r), cmd.scale_mode);
        OP_PA2: nub_r <= clamp_acc(SUM_W'(st_cur) - SUM_W'(r), cmd.scale_mode);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      if (out_shr > (ST_W+1)'(24'sh7fffff)) out_r <= {1'b0, {(SAMP_W-1){1'b1}}};
      else if (out_shr < -(ST_W+1)'(33'sh800000)) out_r <= {1'b1, {(SAMP_W-1){1'b0}}};
      else out_r <= out_shr[SAMP_W-1:0];
    end
  end

  assign sts.order    = order_r;
  assign sts.div_done = div_done;
  assign out_shaping_term = out_r;

endmodule

[design/wlns_ctrl.sv]
module wlns_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_func,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output wlns_pkg::cmd_t cmd,
  input  wlns_pkg::sts_t sts
);
  import wlns_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_APPLY_CHK, S_RUN_MUL, S_RUN_WB, S_DIV_GO, S_DIV_WAIT,
    S_PRED_INIT, S_FIN_MUL, S_FIN_WB, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PASS_SAMPLE, PASS_SCALE, PASS_PRED
  } pass_t;

  state_t           state_r, state_nxt;
  pass_t            pass_r, pass_nxt;
  logic [ORD_W-1:0] idx_r, idx_nxt;
  logic [2:0]       step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             acc;
  op_t              op_cur;
  logic             op_last;
  func_t            func;

  assign func     = func_t'(in_func);
  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;

  // micro-op sequence of each pass over one stage
  always_comb begin
    op_last = 1'b0;
    unique case (pass_r)
      PASS_SAMPLE: begin
        unique case (step_r)
          3'd0: op_cur = OP_AP1;
          3'd1: op_cur = OP_AP2;
          3'd2: op_cur = OP_AP3;
          3'd3: op_cur = OP_LA1;
          3'd4: op_cur = OP_LA2;
          3'd5: op_cur = OP_LN1;
          default: begin op_cur = OP_LN2; op_last = 1'b1; end
        endcase
      end
      PASS_SCALE: begin
        unique case (step_r)
          3'd0: op_cur = OP_SB;
          3'd1: op_cur = OP_LA1;
          default: begin op_cur = OP_LA2; op_last = 1'b1; end
        endcase
      end
      default: begin
        unique case (step_r)
          3'd0: op_cur = OP_PA1;
          3'd1: op_cur = OP_PA2;
          3'd2: op_cur = OP_LN1;
          default: begin op_cur = OP_LN2; op_last = 1'b1; end
        endcase
      end
    endcase
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd            = '0;
    cmd.op         = op_cur;
    cmd.idx        = idx_r[IDX_W-1:0];
    cmd.scale_mode = (pass_r == PASS_SCALE);
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          idx_nxt  = '0;
          step_nxt = '0;
          unique case (func)
            FUNC_SAMPLE: begin
              cmd.load_sample = 1'b1;
              pass_nxt  = PASS_SAMPLE;
              state_nxt = (sts.order == '0) ? S_FIN_MUL : S_RUN_MUL;
            end
            FUNC_COEF: begin
              cmd.write_coef = 1'b1;
              state_nxt = S_OUT;
            end
            FUNC_APPLY: begin
              cmd.load_apply = 1'b1;
              pass_nxt  = PASS_SCALE;
              state_nxt = S_APPLY_CHK;
            end
            default: begin
              cmd.clear_state = 1'b1;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_APPLY_CHK: state_nxt = (sts.order == '0) ? S_DIV_GO : S_RUN_MUL;
      S_RUN_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_RUN_WB;
      end
      S_RUN_WB: begin
        cmd.wb_en = 1'b1;
        state_nxt = S_RUN_MUL;
        if (op_last) begin
          step_nxt = '0;
          idx_nxt  = idx_r + ORD_W'(1);
          if (idx_r + ORD_W'(1) == sts.order) begin
            state_nxt = (pass_r == PASS_SCALE) ? S_DIV_GO : S_FIN_MUL;
          end
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (sts.div_done) state_nxt = S_PRED_INIT;
      S_PRED_INIT: begin
        cmd.pred_init = 1'b1;
        pass_nxt  = PASS_PRED;
        idx_nxt   = '0;
        step_nxt  = '0;
        state_nxt = (sts.order == '0) ? S_FIN_MUL : S_RUN_MUL;
      end
      S_FIN_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.op     = OP_SC;
        state_nxt  = S_FIN_WB;
      end
      S_FIN_WB: begin
        cmd.wb_en = 1'b1;
        cmd.op    = OP_SC;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= PASS_SAMPLE;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // an accepted item always leaves idle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> in_stall)
    else $error("accepted item did not start work");

  // a new result only comes out of the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_valid_r) || !$past(out_stall)) && out_valid_r |-> $past(state_r == S_OUT))
    else $error("result shown from wrong state");

  // stage walk stays inside the active order
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN_MUL |-> idx_r < sts.order)
    else $error("stage index beyond order");

endmodule

[design/warped_lattice_noise_shaper_top.sv]
// channel  direction  ports                                                    handshake
// in       input      in_func in_sample in_coef_index in_coef_value            in_valid/in_stall
//                     in_new_lambda in_new_order
// out      output     out_shaping_term                                         out_valid/out_stall
//
// one beat in, one beat out; one item is worked on at a time
// sample: one pass over active stages (shared multiplier, multiply then write back), then scaling
// apply: a scale pass over the stages, the bit-serial divider with its start,
//   a prediction pass over the stages after, then scaling
// coefficient write and state reset: straight to the output state
// synchronous active-low reset; a result waits in the output register while the next beat enters
module warped_lattice_noise_shaper_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic signed [wlns_pkg::SAMP_W-1:0] in_sample,
  input  logic [wlns_pkg::IDX_W-1:0]         in_coef_index,
  input  logic signed [wlns_pkg::COEF_W-1:0] in_coef_value,
  input  logic signed [wlns_pkg::COEF_W-1:0] in_new_lambda,
  input  logic [wlns_pkg::ORD_W-1:0]         in_new_order,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [wlns_pkg::SAMP_W-1:0] out_shaping_term
);
  import wlns_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  wlns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // lattice datapath
  wlns_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .in_coef_index    (in_coef_index),
    .in_coef_value    (in_coef_value),
    .in_new_lambda    (in_new_lambda),
    .in_new_order     (in_new_order),
    .out_shaping_term (out_shaping_term)
  );

endmodule
